>>> src/olir_pkg.sv
// Shared types and constants for the ordered list insert/remove block.
package olir_pkg;

    // Default list capacity
    localparam int DEPTH_DEF = 32;

    // Fixed field widths
    localparam int VAL_W   = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 3;
    localparam int ECNT_W  = 6;
    localparam int IN_DW   = 32;
    localparam int OUT_DW  = 40;

    // Operation selector carried on the slave tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_HEAD = 2'd0,
        CMD_PUSH_TAIL = 2'd1,
        CMD_REMOVE    = 2'd2,
        CMD_DUMP      = 2'd3
    } t_cmd;

    // Result status carried on the master tuser
    typedef enum logic [STAT_W-1:0] {
        STAT_DONE     = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_NOTFOUND = 3'd2,
        STAT_ENTRY    = 3'd3,
        STAT_EMPTY    = 3'd4
    } t_status;

endpackage

>>> src/olir_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module olir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/ordered_list_insert_remove_top.sv
// Top level: bounded ordered list with head/tail insert, remove-first-match and dump.
//
// The list lives in a circular RAM of DEPTH words addressed from a head pointer, so an
// insert at either end is a single write, made when the input is accepted; the result
// is then loaded in the response state. A remove walks the list through the RAM's single
// registered read port, one entry at a time (read, then compare), and then closes the gap
// with one read/write pair per later entry. A dump reads one entry at a time and hands
// each to the output register, waiting while the output side stalls. The slave side is
// ready only while the sequencer is idle; a finished result waits in the output register
// without holding off the next input transaction. The store starts empty; entry_count
// reports the fill level modulo 64.
module ordered_list_insert_remove_top
    import olir_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input transactions
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [IN_DW-1:0]  i_s_axis_tdata,   // [31:0] value
    input  logic [CMD_W-1:0]  i_s_axis_tuser,   // [1:0] cmd
    // Result transactions
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [OUT_DW-1:0] o_m_axis_tdata,   // [31:0] entry_value, [37:32] entry_count, zero pad
    output logic [STAT_W-1:0] o_m_axis_tuser,   // [2:0] status
    output logic              o_m_axis_tlast    // last
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_RESP   = 8'b0000_0010,
        ST_SC_RD  = 8'b0000_0100,
        ST_SC_CMP = 8'b0000_1000,
        ST_SH_RD  = 8'b0001_0000,
        ST_SH_WR  = 8'b0010_0000,
        ST_DP_RD  = 8'b0100_0000,
        ST_DP_OUT = 8'b1000_0000
    } t_state;

    // Circular address: base plus offset, folded back below DEPTH
    function automatic logic [IW-1:0] wrap_addr(input logic [IW-1:0] base,
                                                input logic [IW-1:0] off);
        logic [IW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IW+1)'(DEPTH)) begin
            sum = sum - (IW+1)'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [IW-1:0]      r_head, n_head;
    logic [IW-1:0]      r_idx, n_idx;
    logic [VAL_W-1:0]   r_val, n_val;
    t_status            r_status, n_status;

    logic               r_out_vld, n_out_vld;
    t_status            r_out_status, n_out_status;
    logic [VAL_W-1:0]   r_out_val, n_out_val;
    logic               r_out_last, n_out_last;
    logic [ECNT_W-1:0]  r_out_cnt, n_out_cnt;

    logic               s_acc;
    logic               out_free;
    t_cmd               in_cmd;
    logic               full;
    logic [IW-1:0]      head_dec;
    logic [CW-1:0]      idx_p1;
    logic [CW-1:0]      idx_p2;
    logic               idx_last;

    logic               rd_en;
    logic               rd_off;
    logic [IW-1:0]      rd_addr;
    logic [VAL_W-1:0]   rd_data;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [VAL_W-1:0]   wr_data;

    assign s_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_vld || i_m_axis_tready;
    assign in_cmd   = t_cmd'(i_s_axis_tuser);
    assign full     = (r_count == CW'(DEPTH));
    assign head_dec = (r_head == '0) ? IW'(DEPTH - 1) : r_head - IW'(1);
    assign idx_p1   = CW'(r_idx) + CW'(1);
    assign idx_p2   = CW'(r_idx) + CW'(2);
    assign idx_last = (idx_p1 == r_count);

    // Shared address unit: one read and one write address per cycle
    assign rd_addr = wrap_addr(r_head, r_idx + IW'(rd_off));

    always_comb begin
        if (r_state == ST_IDLE && in_cmd == CMD_PUSH_HEAD) begin
            wr_addr = head_dec;
        end else if (r_state == ST_IDLE) begin
            wr_addr = wrap_addr(r_head, IW'(r_count));
        end else begin
            wr_addr = wrap_addr(r_head, r_idx);
        end
    end

    assign wr_data = (r_state == ST_IDLE) ? i_s_axis_tdata[VAL_W-1:0] : rd_data;

    olir_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_list_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_head       = r_head;
        n_idx        = r_idx;
        n_val        = r_val;
        n_status     = r_status;
        n_out_vld    = r_out_vld && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_val    = r_out_val;
        n_out_last   = r_out_last;
        n_out_cnt    = r_out_cnt;
        rd_en        = 1'b0;
        rd_off       = 1'b0;
        wr_en        = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_val = i_s_axis_tdata[VAL_W-1:0];
                    n_idx = '0;
                    unique case (in_cmd)
                        CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
                            n_state = ST_RESP;
                            if (full) begin
                                n_status = STAT_FULL;
                            end else begin
                                wr_en    = 1'b1;
                                n_count  = r_count + CW'(1);
                                n_status = STAT_DONE;
                                if (in_cmd == CMD_PUSH_HEAD) begin
                                    n_head = head_dec;
                                end
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = STAT_NOTFOUND;
                                n_state  = ST_RESP;
                            end else begin
                                n_state = ST_SC_RD;
                            end
                        end
                        CMD_DUMP: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                                n_state  = ST_RESP;
                            end else begin
                                n_state = ST_DP_RD;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_status;
                    n_out_val    = '0;
                    n_out_last   = 1'b1;
                    n_out_cnt    = ECNT_W'(r_count);
                    n_state      = ST_IDLE;
                end
            end
            // Search from the head for the first match
            ST_SC_RD: begin
                rd_en   = 1'b1;
                n_state = ST_SC_CMP;
            end
            ST_SC_CMP: begin
                if (rd_data == r_val) begin
                    if (idx_last) begin
                        n_count  = r_count - CW'(1);
                        n_status = STAT_DONE;
                        n_state  = ST_RESP;
                    end else begin
                        n_state = ST_SH_RD;
                    end
                end else if (idx_last) begin
                    n_status = STAT_NOTFOUND;
                    n_state  = ST_RESP;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = ST_SC_RD;
                end
            end
            // Close the gap: entry idx+1 moves to idx
            ST_SH_RD: begin
                rd_en   = 1'b1;
                rd_off  = 1'b1;
                n_state = ST_SH_WR;
            end
            ST_SH_WR: begin
                wr_en = 1'b1;
                if (idx_p2 == r_count) begin
                    n_count  = r_count - CW'(1);
                    n_status = STAT_DONE;
                    n_state  = ST_RESP;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = ST_SH_RD;
                end
            end
            // Dump from head to tail
            ST_DP_RD: begin
                rd_en   = 1'b1;
                n_state = ST_DP_OUT;
            end
            ST_DP_OUT: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_status = STAT_ENTRY;
                    n_out_val    = rd_data;
                    n_out_last   = idx_last;
                    n_out_cnt    = ECNT_W'(r_count);
                    if (idx_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = ST_DP_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_head    <= '0;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_head    <= n_head;
            r_idx     <= n_idx;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_val        <= n_val;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_val    <= n_out_val;
        r_out_last   <= n_out_last;
        r_out_cnt    <= n_out_cnt;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {(OUT_DW - VAL_W - ECNT_W)'(0), r_out_cnt, r_out_val};
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("list fill count exceeds capacity");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_axis_tready)
        else $error("input taken again before the sequencer finished");

    a_nonlast_is_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_last) |-> (r_out_status == STAT_ENTRY))
        else $error("only dump results may be non-final");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_axis_tready) |=> (r_out_vld && $stable(r_out_val) &&
            $stable(r_out_status) && $stable(r_out_last) && $stable(r_out_cnt)))
        else $error("stalled result changed before it was taken");

endmodule
